FILE: design/mdpf_pkg.sv
// mdpf_pkg: shared types, codes and defaults of the maze path finder
// used by the top level, the search controller and the checker; no dependencies
`default_nettype none
package mdpf_pkg;

	localparam int MAX_ROWS_DEF    = 16;
	localparam int MAX_COLS_DEF    = 16;
	localparam int STACK_DEPTH_DEF = 64;

	localparam int CFG_W = 5;
	localparam logic [CFG_W-1:0] GRID_ROWS_RST = 5'd10;
	localparam logic [CFG_W-1:0] GRID_COLS_RST = 5'd10;

	typedef enum logic [0:0] {
		CFG_GRID_ROWS = 1'b0,
		CFG_GRID_COLS = 1'b1
	} cfg_idx_t;

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_START = 1'b1;

	localparam logic [1:0] KIND_WALL = 2'd1;
	localparam logic [1:0] KIND_EXIT = 2'd2;

	localparam logic [1:0] STAT_PATH     = 2'd0;
	localparam logic [1:0] STAT_NO_EXIT  = 2'd1;
	localparam logic [1:0] STAT_OVERFLOW = 2'd2;

	// move directions, tried in circular order
	localparam logic [1:0] DIR_RIGHT = 2'd0;
	localparam logic [1:0] DIR_DOWN  = 2'd1;
	localparam logic [1:0] DIR_LEFT  = 2'd2;
	localparam logic [1:0] DIR_UP    = 2'd3;

	// request fields, first field in the highest bits
	typedef struct packed {
		logic [3:0] entry_col;
		logic [3:0] entry_row;
		logic [1:0] cell_kind;
		logic [3:0] cell_col;
		logic [3:0] cell_row;
	} req_t;

	typedef struct packed {
		logic [3:0] path_x;
		logic [3:0] path_y;
		logic [1:0] search_status;
		logic       last_of_run;
	} res_t;

endpackage
`default_nettype wire

FILE: design/maze_dfs_path_finder_unit.sv
// maze_dfs_path_finder_unit: top level of the maze path finder
// depends on mdpf_pkg, mdpf_ram and mdpf_search_ctrl
//
// Usage. The slave stream takes requests: tuser 0 writes one grid cell (open, wall,
// exit), tuser 1 starts a depth-first search from the entry cell. A load transaction
// gives no result and keeps s_tready high, so cells can stream in back to back. A
// search returns the path cells on the master stream from the entry outwards, x =
// column and y = rows-1-row, status 0, tlast on the final cell; or one status
// transaction with tuser 1 (no exit reachable) or 2 (stack overflow). While a search
// runs s_tready is low; it rises again once the final result is in the output
// register. If the receiver stalls, the output register holds and the block waits.
// Reset empties the stack and sets the grid to 10 x 10; the maze memory holds nothing
// defined until cells are loaded, so no clearing pass is needed. Grid size is written
// on the cfg port (index 0 rows, 1 columns); the user must write it only while the
// block is idle, as the block itself does not enforce this.
`default_nettype none
module maze_dfs_path_finder_unit import mdpf_pkg::*; #(
	parameter int MAX_ROWS    = MAX_ROWS_DEF,
	parameter int MAX_COLS    = MAX_COLS_DEF,
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [23:0]      s_tdata,   // cell_row, cell_col, cell_kind, entry_row, entry_col
	input  logic [0:0]       s_tuser,   // req_type
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [7:0]       m_tdata,   // path_x, path_y
	output logic             m_tlast,
	output logic [1:0]       m_tuser,   // search_status
	input  logic             cfg_we,
	input  logic [0:0]       cfg_addr,
	input  logic [CFG_W-1:0] cfg_wdata
);

	localparam int RW  = ($clog2(MAX_ROWS) > 4) ? $clog2(MAX_ROWS) : 4;
	localparam int CW  = ($clog2(MAX_COLS) > 4) ? $clog2(MAX_COLS) : 4;
	localparam int MAW = $clog2(MAX_ROWS) + $clog2(MAX_COLS);
	localparam int SAW = $clog2(STACK_DEPTH);
	localparam int SDW = RW + CW + 4;

	logic [CFG_W-1:0] rows_cfg_q;
	logic [CFG_W-1:0] cols_cfg_q;
	logic [RW:0]      rows_x;
	logic [CW:0]      cols_x;
	logic [RW:0]      rows_used;
	logic [CW:0]      cols_used;

	req_t             req;
	res_t             res;

	logic             maze_we;
	logic [MAW-1:0]   maze_waddr;
	logic [1:0]       maze_wdata;
	logic             maze_re;
	logic [MAW-1:0]   maze_raddr;
	logic [1:0]       maze_rdata;
	logic             stk_we;
	logic [SAW-1:0]   stk_waddr;
	logic [SDW-1:0]   stk_wdata;
	logic             stk_re;
	logic [SAW-1:0]   stk_raddr;
	logic [SDW-1:0]   stk_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_cfg_q <= GRID_ROWS_RST;
			cols_cfg_q <= GRID_COLS_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_addr))
				CFG_GRID_ROWS: rows_cfg_q <= cfg_wdata;
				CFG_GRID_COLS: cols_cfg_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// grid size clamped to 1 .. storage size
	assign rows_x = (RW+1)'(rows_cfg_q);
	assign cols_x = (CW+1)'(cols_cfg_q);

	always_comb begin
		priority if (rows_x == '0) begin
			rows_used = (RW+1)'(1);
		end else if (rows_x > (RW+1)'(MAX_ROWS)) begin
			rows_used = (RW+1)'(MAX_ROWS);
		end else begin
			rows_used = rows_x;
		end
		priority if (cols_x == '0) begin
			cols_used = (CW+1)'(1);
		end else if (cols_x > (CW+1)'(MAX_COLS)) begin
			cols_used = (CW+1)'(MAX_COLS);
		end else begin
			cols_used = cols_x;
		end
	end

	assign req      = s_tdata[$bits(req_t)-1:0];
	assign m_tdata  = {res.path_y, res.path_x};
	assign m_tuser  = res.search_status;
	assign m_tlast  = res.last_of_run;

	mdpf_ram #(.AW(MAW), .DW(2)) u_maze_mem (
		.clk   (clk),
		.we    (maze_we),
		.waddr (maze_waddr),
		.wdata (maze_wdata),
		.re    (maze_re),
		.raddr (maze_raddr),
		.rdata (maze_rdata)
	);

	mdpf_ram #(.AW(SAW), .DW(SDW)) u_stack_mem (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.re    (stk_re),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	mdpf_search_ctrl #(
		.MAX_ROWS    (MAX_ROWS),
		.MAX_COLS    (MAX_COLS),
		.STACK_DEPTH (STACK_DEPTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_type    (s_tuser[0]),
		.in_req     (req),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_res    (res),
		.rows_used  (rows_used),
		.cols_used  (cols_used),
		.maze_we    (maze_we),
		.maze_waddr (maze_waddr),
		.maze_wdata (maze_wdata),
		.maze_re    (maze_re),
		.maze_raddr (maze_raddr),
		.maze_rdata (maze_rdata),
		.stk_we     (stk_we),
		.stk_waddr  (stk_waddr),
		.stk_wdata  (stk_wdata),
		.stk_re     (stk_re),
		.stk_raddr  (stk_raddr),
		.stk_rdata  (stk_rdata)
	);

endmodule
`default_nettype wire

FILE: design/mdpf_ram.sv
// mdpf_ram: simple dual-port synchronous memory, one write and one registered read port
// depends on nothing; used for the maze grid and the move stack
`default_nettype none
module mdpf_ram #(
	parameter int AW = 8,
	parameter int DW = 2
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [(1 << AW)];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

FILE: design/mdpf_search_ctrl.sv
// mdpf_search_ctrl: request handling, depth-first search sequencer and result register
// depends on mdpf_pkg; drives the maze and stack memories built from mdpf_ram
`default_nettype none
module mdpf_search_ctrl import mdpf_pkg::*; #(
	parameter int MAX_ROWS    = MAX_ROWS_DEF,
	parameter int MAX_COLS    = MAX_COLS_DEF,
	parameter int STACK_DEPTH = STACK_DEPTH_DEF,
	localparam int RW  = ($clog2(MAX_ROWS) > 4) ? $clog2(MAX_ROWS) : 4,
	localparam int CW  = ($clog2(MAX_COLS) > 4) ? $clog2(MAX_COLS) : 4,
	localparam int MRW = $clog2(MAX_ROWS),
	localparam int MCW = $clog2(MAX_COLS),
	localparam int SAW = $clog2(STACK_DEPTH),
	localparam int SDW = RW + CW + 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             in_type,
	input  req_t             in_req,
	output logic             out_valid,
	input  logic             out_ready,
	output res_t             out_res,
	input  logic [RW:0]      rows_used,
	input  logic [CW:0]      cols_used,
	output logic             maze_we,
	output logic [MRW+MCW-1:0] maze_waddr,
	output logic [1:0]       maze_wdata,
	output logic             maze_re,
	output logic [MRW+MCW-1:0] maze_raddr,
	input  logic [1:0]       maze_rdata,
	output logic             stk_we,
	output logic [SAW-1:0]   stk_waddr,
	output logic [SDW-1:0]   stk_wdata,
	output logic             stk_re,
	output logic [SAW-1:0]   stk_raddr,
	input  logic [SDW-1:0]   stk_rdata
);

	typedef enum logic [3:0] {
		S_IDLE, S_ENTRY, S_TRY, S_CHECK, S_POP, S_EMIT_RD, S_EMIT_WR, S_EMIT_TOP, S_STATUS
	} state_t;

	typedef struct packed {
		logic [RW-1:0] row;
		logic [CW-1:0] col;
		logic [1:0]    excl;
		logic [1:0]    nxt;
	} entry_t;

	state_t         state_q;
	logic [SAW:0]   top_q;
	logic [RW-1:0]  cur_row_q;
	logic [CW-1:0]  cur_col_q;
	logic [1:0]     excl_q;
	logic [1:0]     next_q;
	logic [RW-1:0]  cand_row_q;
	logic [CW-1:0]  cand_col_q;
	logic [1:0]     dir_q;
	logic           entry_ok_q;
	logic [SAW-1:0] emit_idx_q;
	logic [1:0]     status_q;
	logic           out_valid_q;
	res_t           out_q;

	logic           in_fire;
	logic           out_free;
	logic [RW:0]    entry_row_x;
	logic [CW:0]    entry_col_x;
	logic           entry_in;
	logic           load_ok;
	logic [RW:0]    cand_row;
	logic [CW:0]    cand_col;
	logic           cand_ok;
	logic           cand_in;
	logic           dir_left;
	logic [SAW:0]   top_m1;
	logic [SAW:0]   top_m2;
	entry_t         rd_ent;
	entry_t         emit_ent;
	logic [RW:0]    emit_y;

	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	assign entry_row_x = (RW+1)'(in_req.entry_row);
	assign entry_col_x = (CW+1)'(in_req.entry_col);
	assign entry_in    = (entry_row_x < rows_used) && (entry_col_x < cols_used);
	assign load_ok     = ((RW+1)'(in_req.cell_row) < (RW+1)'(MAX_ROWS)) &&
		((CW+1)'(in_req.cell_col) < (CW+1)'(MAX_COLS));

	// neighbour of the top cell in the direction under trial
	always_comb begin
		cand_row = {1'b0, cur_row_q};
		cand_col = {1'b0, cur_col_q};
		cand_ok  = 1'b1;
		unique case (next_q)
			DIR_RIGHT: cand_col = {1'b0, cur_col_q} + (CW+1)'(1);
			DIR_DOWN:  cand_row = {1'b0, cur_row_q} + (RW+1)'(1);
			DIR_LEFT: begin
				cand_ok  = (cur_col_q != '0);
				cand_col = {1'b0, cur_col_q} - (CW+1)'(1);
			end
			DIR_UP: begin
				cand_ok  = (cur_row_q != '0);
				cand_row = {1'b0, cur_row_q} - (RW+1)'(1);
			end
			default: cand_ok = 1'b0;
		endcase
	end

	assign cand_in  = cand_ok && (cand_row < rows_used) && (cand_col < cols_used);
	assign dir_left = (next_q != excl_q);
	assign top_m1   = top_q - (SAW+1)'(1);
	assign top_m2   = top_q - (SAW+1)'(2);
	assign rd_ent   = stk_rdata;

	// path cell on its way out: from memory, or the top entry held in registers
	assign emit_ent = (state_q == S_EMIT_TOP) ? {cur_row_q, cur_col_q, excl_q, next_q} : rd_ent;
	assign emit_y   = rows_used - (RW+1)'(1) - {1'b0, emit_ent.row};

	// memory ports
	always_comb begin
		maze_we    = in_fire && (in_type == REQ_LOAD) && load_ok;
		maze_waddr = {MRW'(in_req.cell_row), MCW'(in_req.cell_col)};
		maze_wdata = in_req.cell_kind;
		maze_re    = (in_fire && (in_type == REQ_START)) ||
			((state_q == S_TRY) && dir_left && cand_in);
		maze_raddr = (state_q == S_IDLE) ? {entry_row_x[MRW-1:0], entry_col_x[MCW-1:0]}
			: {cand_row[MRW-1:0], cand_col[MCW-1:0]};
		stk_we     = (state_q == S_CHECK) && (maze_rdata != KIND_WALL) &&
			(top_q != (SAW+1)'(STACK_DEPTH));
		stk_waddr  = top_m1[SAW-1:0];
		stk_wdata  = {cur_row_q, cur_col_q, excl_q, dir_q + 2'd1};
		stk_re     = ((state_q == S_TRY) && !dir_left && (top_q != (SAW+1)'(1))) ||
			(state_q == S_EMIT_RD);
		stk_raddr  = (state_q == S_EMIT_RD) ? emit_idx_q : top_m2[SAW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			top_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire && (in_type == REQ_START)) begin
						cur_row_q  <= entry_row_x[RW-1:0];
						cur_col_q  <= entry_col_x[CW-1:0];
						excl_q     <= DIR_RIGHT;
						next_q     <= DIR_DOWN;
						top_q      <= (SAW+1)'(1);
						entry_ok_q <= entry_in;
						state_q    <= S_ENTRY;
					end
				end
				S_ENTRY: begin
					emit_idx_q <= '0;
					if (entry_ok_q && (maze_rdata == KIND_EXIT)) begin
						state_q <= S_EMIT_TOP;
					end else begin
						state_q <= S_TRY;
					end
				end
				S_TRY: begin
					if (!dir_left) begin
						// dead end: pop
						top_q <= top_m1;
						if (top_q == (SAW+1)'(1)) begin
							status_q <= STAT_NO_EXIT;
							state_q  <= S_STATUS;
						end else begin
							state_q <= S_POP;
						end
					end else if (cand_in) begin
						cand_row_q <= cand_row[RW-1:0];
						cand_col_q <= cand_col[CW-1:0];
						dir_q      <= next_q;
						state_q    <= S_CHECK;
					end else begin
						next_q <= next_q + 2'd1;
					end
				end
				S_CHECK: begin
					if (maze_rdata == KIND_WALL) begin
						next_q  <= dir_q + 2'd1;
						state_q <= S_TRY;
					end else if (top_q == (SAW+1)'(STACK_DEPTH)) begin
						top_q    <= '0;
						status_q <= STAT_OVERFLOW;
						state_q  <= S_STATUS;
					end else begin
						// old top went to memory this cycle, new cell stays in registers
						cur_row_q  <= cand_row_q;
						cur_col_q  <= cand_col_q;
						excl_q     <= dir_q + 2'd2;
						next_q     <= dir_q + 2'd3;
						top_q      <= top_q + (SAW+1)'(1);
						emit_idx_q <= '0;
						state_q    <= (maze_rdata == KIND_EXIT) ? S_EMIT_RD : S_TRY;
					end
				end
				S_POP: begin
					cur_row_q <= rd_ent.row;
					cur_col_q <= rd_ent.col;
					excl_q    <= rd_ent.excl;
					next_q    <= rd_ent.nxt;
					state_q   <= S_TRY;
				end
				S_EMIT_RD: begin
					state_q <= S_EMIT_WR;
				end
				S_EMIT_WR: begin
					if (out_free) begin
						out_q       <= '{path_x: emit_ent.col[3:0], path_y: emit_y[3:0],
							search_status: STAT_PATH, last_of_run: 1'b0};
						out_valid_q <= 1'b1;
						emit_idx_q  <= emit_idx_q + SAW'(1);
						if (({1'b0, emit_idx_q} + (SAW+1)'(1)) == top_m1) begin
							state_q <= S_EMIT_TOP;
						end else begin
							state_q <= S_EMIT_RD;
						end
					end
				end
				S_EMIT_TOP: begin
					if (out_free) begin
						out_q       <= '{path_x: emit_ent.col[3:0], path_y: emit_y[3:0],
							search_status: STAT_PATH, last_of_run: 1'b1};
						out_valid_q <= 1'b1;
						top_q       <= '0;
						state_q     <= S_IDLE;
					end
				end
				S_STATUS: begin
					if (out_free) begin
						out_q       <= '{path_x: 4'd0, path_y: 4'd0,
							search_status: status_q, last_of_run: 1'b1};
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: design/mdpf_checker.sv
// mdpf_checker: port-level assertions on the maze path finder, bound to the top level
// depends on mdpf_pkg and maze_dfs_path_finder_unit
`default_nettype none
module mdpf_checker import mdpf_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic [0:0] s_tuser,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast,
	input logic [1:0] m_tuser
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("result changed while stalled");

	// a status transaction ends the run and carries no coordinates
	a_status_form: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != STAT_PATH) |-> m_tlast && (m_tdata == 8'd0))
		else $error("malformed status transaction");

	// a start transaction closes the request side while the search runs
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser[0] == REQ_START) |=> !s_tready)
		else $error("request accepted during search");

	// a cell load keeps the request side open
	a_load_open: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser[0] == REQ_LOAD) |=> s_tready)
		else $error("load transaction stalled the request side");

endmodule

bind maze_dfs_path_finder_unit mdpf_checker u_mdpf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);
`default_nettype wire
